// ===== sv/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
package bra_pkg;

    localparam int UNIT_W      = 8;                 // units per map byte
    localparam int LANE_AW     = $clog2(UNIT_W);    // bit position inside a byte
    localparam int ROW_BYTES   = 8;                 // bytes per storage row
    localparam int ROW_W       = ROW_BYTES * UNIT_W;
    localparam int ROW_SH      = $clog2(ROW_W);     // unit index to row index shift
    localparam int INDEX_BYTES = 512;               // bytes a 12-bit unit index reaches
    localparam int IDX_W       = 12;
    localparam int LEN_W       = 13;
    localparam int CFG_W       = 10;

    typedef enum logic [1:0] {
        CMD_SCAN  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_TEST  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic               hit;
        logic [LANE_AW-1:0] pos;
        logic [LEN_W-1:0]   run;
    } t_lane_res;

endpackage

// ===== sv/bitmap_run_allocator_unit.sv =====
// Top level of the bitmap run allocator: command sequencer, config register, result register.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -------------------------------------
//  in        input      i_in_valid / o_in_stall   i_cmd, i_bit_index, i_run_length
//  out       output     o_out_valid / i_out_stall o_found, o_start_index, o_bit_value
//  cfg       input      i_cfg_we                  i_cfg_wdata (bytes in use)
//
//  Set, clear and test inside the map pass from accept through a row read, then read-modify-write,
//  to the result register; out of range they finish in the accept cycle.
//  Scan reads each 64-unit row, then passes it whole if it is wholly used or skippable free,
//  else steps through it one byte per cycle in the shared byte step unit.
//  Reset clears the control state, the row valid flags (so the map reads all free)
//  and sets bytes in use to 512. No clearing pass.
//  One command at a time; a waiting result beat holds the block in idle until taken.
module bitmap_run_allocator_unit import bra_pkg::*; #(
    parameter int MAP_BYTES = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_cmd,
    input  logic [IDX_W-1:0] i_bit_index,
    input  logic [LEN_W-1:0] i_run_length,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_found,
    output logic [IDX_W-1:0] o_start_index,
    output logic             o_bit_value
);

    // Storage never exceeds what a 12-bit unit index can reach.
    localparam int STORE_BYTES = (MAP_BYTES < INDEX_BYTES) ? MAP_BYTES : INDEX_BYTES;
    localparam int ROWS        = (STORE_BYTES + ROW_BYTES - 1) / ROW_BYTES;
    localparam int AW          = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [CFG_W-1:0] STORE_BYTES_C = CFG_W'(STORE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_RMW,
        S_DONE
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [LEN_W-1:0] r_len;
    logic [CFG_W-1:0] r_byte;        // byte pointer of the scan
    logic [LEN_W-1:0] r_run;         // free units counted so far
    logic             r_hit;
    logic [IDX_W-1:0] r_end;         // last unit of the found run
    logic [CFG_W-1:0] r_bytes_in_use;
    logic             r_out_valid;
    logic             r_found;
    logic [IDX_W-1:0] r_start;
    logic             r_bitv;

    // Effective map size and handshake terms.
    logic [CFG_W-1:0] nb;
    logic [LEN_W-1:0] total;
    logic             out_free;
    logic             in_acc;
    t_cmd             in_cmd;
    logic             out_load;

    assign nb       = (r_bytes_in_use < STORE_BYTES_C) ? r_bytes_in_use : STORE_BYTES_C;
    assign total    = {nb, {LANE_AW{1'b0}}};
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign in_cmd   = t_cmd'(i_cmd);

    // A result beat is loaded on an immediate answer in idle, or at the end of a command.
    assign out_load = ((r_state == S_IDLE) && in_acc &&
                       ((in_cmd == CMD_SCAN) ? ((i_run_length == '0) || (i_run_length > total))
                                             : ({1'b0, i_bit_index} >= total)))
                   || (((r_state == S_RMW) || (r_state == S_DONE)) && out_free);

    // Map storage and its port control.
    logic [ROW_W-1:0] row_data;
    logic [ROW_W-1:0] bit_mask;
    logic [ROW_W-1:0] wr_data;
    logic [AW-1:0]    mem_addr;
    logic             mem_rd_en;
    logic             mem_wr_en;

    assign mem_addr  = (r_cmd == CMD_SCAN) ? r_byte[LANE_AW +: AW] : r_idx[ROW_SH +: AW];
    assign mem_rd_en = (r_state == S_READ);
    assign mem_wr_en = (r_state == S_RMW) && out_free && (r_cmd != CMD_TEST);
    assign bit_mask  = ROW_W'(1) << r_idx[ROW_SH-1:0];
    assign wr_data   = (r_cmd == CMD_SET) ? (row_data | bit_mask) : (row_data & ~bit_mask);

    bra_map_mem #(
        .ROWS (ROWS)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_wr_en   (mem_wr_en),
        .i_addr    (mem_addr),
        .i_wr_data (wr_data),
        .o_rd_data (row_data)
    );

    // Shared byte step unit, fed the current byte lane of the held row.
    logic [UNIT_W-1:0] lane_byte;
    t_lane_res         lane_res;

    assign lane_byte = row_data[{r_byte[LANE_AW-1:0], {LANE_AW{1'b0}}} +: UNIT_W];

    bra_lane_step u_step (
        .i_byte (lane_byte),
        .i_run  (r_run),
        .i_len  (r_len),
        .o_res  (lane_res)
    );

    // Whole-row shortcuts: a full row resets the run, a free row that cannot
    // complete the run just adds 64 units.
    logic             row_fits;
    logic             row_used;
    logic             skip_free;
    logic             skip_row;
    logic [LEN_W-1:0] run64;
    logic [CFG_W-1:0] byte_next;

    assign row_fits  = ({1'b0, r_byte} + (CFG_W+1)'(ROW_BYTES)) <= {1'b0, nb};
    assign row_used  = &row_data;
    assign run64     = r_run + LEN_W'(ROW_W);
    assign skip_free = (row_data == '0) && (run64 < r_len);
    assign skip_row  = (r_byte[LANE_AW-1:0] == '0) && row_fits && (row_used || skip_free);
    assign byte_next = r_byte + (skip_row ? CFG_W'(ROW_BYTES) : CFG_W'(1));

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_use <= CFG_W'(INDEX_BYTES);
        end else if (i_cfg_we) begin
            r_bytes_in_use <= i_cfg_wdata;
        end
    end

    // Sequencer with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            // Load a new result beat, else drop the current one once taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd <= in_cmd;
                        r_idx <= i_bit_index;
                        r_len <= i_run_length;
                        if (in_cmd == CMD_SCAN) begin
                            if ((i_run_length == '0) || (i_run_length > total)) begin
                                // Nothing can fit: answer at once.
                                r_found     <= 1'b0;
                                r_start     <= '0;
                                r_bitv      <= 1'b0;
                            end else begin
                                r_byte  <= '0;
                                r_run   <= '0;
                                r_hit   <= 1'b0;
                                r_state <= S_READ;
                            end
                        end else if ({1'b0, i_bit_index} < total) begin
                            r_state <= S_READ;
                        end else begin
                            // Index past the map: no change, test reads zero.
                            r_found     <= 1'b1;
                            r_start     <= '0;
                            r_bitv      <= 1'b0;
                        end
                    end
                end
                S_READ: begin
                    r_state <= (r_cmd == CMD_SCAN) ? S_SCAN : S_RMW;
                end
                S_SCAN: begin
                    if (!skip_row && lane_res.hit) begin
                        r_hit   <= 1'b1;
                        r_end   <= {r_byte[IDX_W-LANE_AW-1:0], lane_res.pos};
                        r_state <= S_DONE;
                    end else begin
                        if (skip_row) begin
                            r_run <= row_used ? '0 : run64;
                        end else begin
                            r_run <= lane_res.run;
                        end
                        r_byte <= byte_next;
                        // Stop at the end of the map, fetch a new row at each row boundary.
                        if (byte_next == nb) begin
                            r_state <= S_DONE;
                        end else if (byte_next[LANE_AW-1:0] == '0) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_RMW: begin
                    if (out_free) begin
                        r_found     <= 1'b1;
                        r_start     <= '0;
                        r_bitv      <= (r_cmd == CMD_TEST) ? row_data[r_idx[ROW_SH-1:0]] : 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_found     <= r_hit;
                        r_start     <= r_hit ? (r_end + IDX_W'(1) - r_len[IDX_W-1:0]) : '0;
                        r_bitv      <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_start_index = r_start;
    assign o_bit_value   = r_bitv;

endmodule

// ===== sv/bra_lane_step.sv =====
// Run counter step over one map byte: carries the free run and flags the first fit.
module bra_lane_step import bra_pkg::*; (
    input  logic [UNIT_W-1:0] i_byte,
    input  logic [LEN_W-1:0]  i_run,
    input  logic [LEN_W-1:0]  i_len,
    output t_lane_res         o_res
);

    always_comb begin
        logic [LEN_W-1:0]   run;
        logic               hit;
        logic [LANE_AW-1:0] pos;
        run = i_run;
        hit = 1'b0;
        pos = '0;
        for (int j = 0; j < UNIT_W; j++) begin
            if (!hit) begin
                if (i_byte[j]) begin
                    run = '0;
                end else begin
                    run = run + 1'b1;
                end
                if (run == i_len) begin
                    hit = 1'b1;
                    pos = LANE_AW'(j);
                end
            end
        end
        o_res.hit = hit;
        o_res.pos = pos;
        o_res.run = run;
    end

endmodule

// ===== sv/bra_map_mem.sv =====
// Usage map storage: one-port row memory with per-row valid flags, unwritten rows read free.
module bra_map_mem import bra_pkg::*; #(
    parameter int  ROWS = 64,
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_addr,
    input  logic [ROW_W-1:0] i_wr_data,
    output logic [ROW_W-1:0] o_rd_data
);

    logic [ROW_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]  r_vld;
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_addr];
            end
            if (i_wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== tb/sv/bra_alloc_checker.sv =====
// Checker for the bitmap run allocator: tracks the usage map, predicts each result beat and compares.
module bra_alloc_checker import bra_pkg::*; #(
    parameter int MAP_BYTES = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [1:0]       i_cmd,
    input  logic [IDX_W-1:0] i_bit_index,
    input  logic [LEN_W-1:0] i_run_length,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic             i_found,
    input  logic [IDX_W-1:0] i_start_index,
    input  logic             i_bit_value,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results,
    output int               o_scan_hits,
    output int               o_scan_misses
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_cmd             cmd;
        logic             found;
        logic [IDX_W-1:0] start_index;
        logic             bit_value;
    } t_alloc_result;

    logic [INDEX_BYTES*UNIT_W-1:0] usage_bits;
    logic [CFG_W-1:0]              cfg_bytes;
    t_alloc_result                 expected_q[$];

    function automatic int active_units();
        int nbytes;
        nbytes = int'(cfg_bytes);
        if (nbytes > MAP_BYTES)
            nbytes = MAP_BYTES;
        if (nbytes > INDEX_BYTES)
            nbytes = INDEX_BYTES;
        return nbytes * UNIT_W;
    endfunction

    // Apply one command to the shadow map and return the beat it should produce.
    function automatic t_alloc_result predict_alloc(t_cmd c, logic [IDX_W-1:0] idx,
                                                    logic [LEN_W-1:0] len);
        t_alloc_result r;
        int total;
        int run;
        total = active_units();
        r.cmd = c;
        r.found = 1'b1;
        r.start_index = '0;
        r.bit_value = 1'b0;
        run = 0;
        if (c == CMD_SCAN) begin
            r.found = 1'b0;
            if (len != 0 && int'(len) <= total) begin
                for (int u = 0; u < total; u++) begin
                    if (usage_bits[u]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == int'(len)) begin
                            r.found = 1'b1;
                            r.start_index = IDX_W'(u + 1 - int'(len));
                            break;
                        end
                    end
                end
            end
        end else if (int'(idx) < total) begin
            case (c)
                CMD_SET:   usage_bits[idx] = 1'b1;
                CMD_CLEAR: usage_bits[idx] = 1'b0;
                default:   r.bit_value = usage_bits[idx];
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            usage_bits    = '0;
            cfg_bytes     = CFG_W'(INDEX_BYTES);
            expected_q.delete();
            o_fail_count  = 0;
            o_results     = 0;
            o_scan_hits   = 0;
            o_scan_misses = 0;
        end else begin
            if (i_cfg_we)
                cfg_bytes = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(predict_alloc(t_cmd'(i_cmd), i_bit_index, i_run_length));
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, found %0d start %0d bit %0d",
                             $time, i_found, i_start_index, i_bit_value);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field($sformatf("%s found", want.cmd.name()), want.found, i_found);
                    check_field($sformatf("%s start_index", want.cmd.name()),
                                want.start_index, i_start_index);
                    check_field($sformatf("%s bit_value", want.cmd.name()),
                                want.bit_value, i_bit_value);
                    if (want.cmd == CMD_SCAN) begin
                        if (want.found)
                            o_scan_hits++;
                        else
                            o_scan_misses++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== tb/sv/tb_bitmap_run_allocator_unit.sv =====
// Testbench top for the bitmap run allocator: clock, reset, stimulus, receiver stalls and verdict.
module tb_bitmap_run_allocator_unit import bra_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_BYTES      = 512;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 5000;  // longest scan plus the long hold, several times over
    localparam int PRESSURE_HOLD  = 400;
    localparam int DRAIN_CYCLES   = 20;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_cfg_we     = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata  = '0;
    logic             i_in_valid   = 1'b0;
    logic [1:0]       i_cmd        = CMD_SCAN;
    logic [IDX_W-1:0] i_bit_index  = '0;
    logic [LEN_W-1:0] i_run_length = '0;
    logic             i_out_stall  = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic             o_found;
    logic [IDX_W-1:0] o_start_index;
    logic             o_bit_value;

    int fail_count;
    int pending;
    int result_beats;
    int scan_hits;
    int scan_misses;

    int cur_bytes     = INDEX_BYTES;  // shadow of bytes in use, for picking indexes
    int setting_count = 0;
    bit sender_burst  = 1'b0;         // no gaps between input beats while set
    bit pressure_done = 1'b0;

    always #2 i_clk = ~i_clk;

    bitmap_run_allocator_unit #(
        .MAP_BYTES(MAP_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_bit_index   (i_bit_index),
        .i_run_length  (i_run_length),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_start_index (o_start_index),
        .o_bit_value   (o_bit_value)
    );

    bra_alloc_checker #(
        .MAP_BYTES(MAP_BYTES)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_bit_index   (i_bit_index),
        .i_run_length  (i_run_length),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_found       (o_found),
        .i_start_index (o_start_index),
        .i_bit_value   (o_bit_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (result_beats),
        .o_scan_hits   (scan_hits),
        .o_scan_misses (scan_misses)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_span();
        int p;
        p = $urandom_range(99, 0);
        if (p < 45)
            return 0;
        if (p < 85)
            return $urandom_range(3, 1);
        if (p < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Offer one command beat and hold it until the block takes it.
    // Valid stays high into the next beat when no gap is picked.
    task automatic send_cmd(input t_cmd c, input logic [IDX_W-1:0] idx,
                            input logic [LEN_W-1:0] len);
        int gap;
        gap = sender_burst ? 0 : idle_span();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= c;
        i_bit_index  <= idx;
        i_run_length <= len;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Drop valid and wait until every expected beat has come back.
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Write bytes in use; only called with the block idle.
    task automatic write_bytes_in_use(input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_bytes = value;
        setting_count++;
    endtask

    task automatic run_random_phase(input int n_items);
        int units;
        int pick;
        int last_idx;
        int near_len;
        t_cmd c;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        units = (cur_bytes > MAP_BYTES) ? MAP_BYTES : cur_bytes;
        if (units > INDEX_BYTES)
            units = INDEX_BYTES;
        units = units * UNIT_W;
        last_idx = 0;
        for (int k = 0; k < n_items; k++) begin
            // switch between gapped and back-to-back stretches
            if (k % 64 == 0)
                sender_burst = ($urandom_range(3, 0) == 0);
            pick = $urandom_range(99, 0);
            if (pick < 30)
                c = CMD_SCAN;
            else if (pick < 60)
                c = CMD_SET;
            else if (pick < 85)
                c = CMD_CLEAR;
            else
                c = CMD_TEST;
            // cluster indexes so used runs build up and fragment the map
            pick = $urandom_range(99, 0);
            if (units == 0 || pick < 12)
                idx = IDX_W'($urandom_range(4095, 0));
            else if (pick < 55)
                idx = IDX_W'((last_idx + $urandom_range(15, 0)) % units);
            else
                idx = IDX_W'($urandom_range(units - 1, 0));
            last_idx = int'(idx);
            pick = $urandom_range(99, 0);
            near_len = units + $urandom_range(4, 0) - 2;
            if (near_len < 0)
                near_len = 0;
            if (pick < 5)
                len = '0;
            else if (pick < 55)
                len = LEN_W'($urandom_range(8, 1));
            else if (pick < 75)
                len = LEN_W'($urandom_range((units > 0) ? units : 1, 1));
            else if (pick < 88)
                len = LEN_W'(near_len);
            else
                len = LEN_W'($urandom_range(8191, 0));
            send_cmd(c, idx, len);
        end
        sender_burst = 1'b0;
    endtask

    // Receiver: random stall stretches, plus one long hold while the sender keeps offering.
    initial begin
        int span;
        int beats;
        span = 0;
        beats = 0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                beats++;
            if (span > 0) begin
                span--;
            end else if (!pressure_done && beats >= 40) begin
                pressure_done = 1'b1;
                i_out_stall <= 1'b1;
                span = PRESSURE_HOLD;
            end else if (i_out_stall) begin
                i_out_stall <= 1'b0;
                span = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 40)
                                                   : $urandom_range(12, 0);
            end else begin
                i_out_stall <= 1'b1;
                span = idle_span();
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int settings[8];
        settings = '{3, 16, 64, 512, 200, 1, 1023, 40};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full map after reset: zero length, exact fit, too long, top bit of length.
        send_cmd(CMD_SCAN,  12'd0,    13'd0);
        send_cmd(CMD_SCAN,  12'd0,    13'd1);
        send_cmd(CMD_SCAN,  12'd0,    13'd4096);
        send_cmd(CMD_SCAN,  12'd0,    13'd4097);
        send_cmd(CMD_SCAN,  12'hfff,  13'h1fff);
        send_cmd(CMD_TEST,  12'd0,    13'd0);
        send_cmd(CMD_SET,   12'd0,    13'd0);
        send_cmd(CMD_TEST,  12'd0,    13'd0);
        send_cmd(CMD_SET,   12'd4095, 13'd0);
        send_cmd(CMD_TEST,  12'd4095, 13'd0);
        // Used units at both ends: the run must stay inside the map.
        send_cmd(CMD_SCAN,  12'd0,    13'd4095);
        send_cmd(CMD_SCAN,  12'd0,    13'd4094);
        send_cmd(CMD_CLEAR, 12'd0,    13'd0);
        send_cmd(CMD_SCAN,  12'd0,    13'd4095);
        send_cmd(CMD_SET,   12'd2048, 13'd0);
        send_cmd(CMD_SCAN,  12'd0,    13'd2048);
        send_cmd(CMD_SCAN,  12'd0,    13'd2049);
        send_cmd(CMD_SET,   12'haaa,  13'h0aaa);
        send_cmd(CMD_TEST,  12'haaa,  13'h1555);
        finish_phase();

        // One byte in use: indexes past the map are ignored, test reads zero.
        write_bytes_in_use(1);
        send_cmd(CMD_SET,   12'd7,    13'd0);
        send_cmd(CMD_SET,   12'd9,    13'd0);
        send_cmd(CMD_TEST,  12'd8,    13'd0);
        send_cmd(CMD_SCAN,  12'd0,    13'd7);
        send_cmd(CMD_SCAN,  12'd0,    13'd8);
        finish_phase();

        // Empty map: nothing fits, nothing changes.
        write_bytes_in_use(0);
        send_cmd(CMD_SCAN,  12'd0,    13'd1);
        send_cmd(CMD_SET,   12'd1,    13'd0);
        finish_phase();

        // Beyond the map size: clamps to the full map.
        write_bytes_in_use(1023);
        send_cmd(CMD_TEST,  12'd9,    13'd0);
        send_cmd(CMD_TEST,  12'd1,    13'd0);
        send_cmd(CMD_SCAN,  12'd0,    13'd4096);
        finish_phase();

        // Random phases over several map sizes; the map carries over between them.
        foreach (settings[s]) begin
            write_bytes_in_use(settings[s]);
            run_random_phase(RANDOM_ITEMS / 8);
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d result beats over %0d map sizes: %0d scans found a run, %0d did not.",
                 result_beats, setting_count, scan_hits, scan_misses);
        $display("Receiver held off %0d cycles once with the sender still offering beats.",
                 pressure_done ? PRESSURE_HOLD : 0);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bra_pkg.sv
sv/bra_lane_step.sv
sv/bra_map_mem.sv
sv/bitmap_run_allocator_unit.sv
tb/sv/bra_alloc_checker.sv
tb/sv/tb_bitmap_run_allocator_unit.sv
